// File: hdl/tvoc_pkg.sv
// Package for the three-voice oscillator/envelope core: opcodes, register
// indexes, envelope phase codes and the rate period table. No dependencies.
`default_nettype none
package tvoc_pkg;
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	localparam logic [4:0] REG_POT_X = 5'h19;
	localparam logic [4:0] REG_POT_Y = 5'h1A;
	localparam logic [4:0] REG_OSC3  = 5'h1B;
	localparam logic [4:0] REG_ENV3  = 5'h1C;

	localparam logic [1:0] EP_ATTACK  = 2'd0;
	localparam logic [1:0] EP_DECAY   = 2'd1;
	localparam logic [1:0] EP_RELEASE = 2'd2;

	localparam logic [22:0] LFSR_RESET = 23'h7FFFF8;

	typedef struct packed {
		logic [23:0] phase;
		logic [22:0] lfsr;
		logic [7:0]  level;
		logic [1:0]  ephase;
		logic [14:0] rcount;
		logic [4:0]  ecount;
	} voice_state_t;

	function automatic logic [14:0] env_step_len(input logic [3:0] r);
		logic [14:0] p;
		unique case (r)
			4'd0: p = 15'd8;      4'd1: p = 15'd31;
			4'd2: p = 15'd62;     4'd3: p = 15'd94;
			4'd4: p = 15'd148;    4'd5: p = 15'd219;
			4'd6: p = 15'd266;    4'd7: p = 15'd312;
			4'd8: p = 15'd391;    4'd9: p = 15'd976;
			4'd10: p = 15'd1953;  4'd11: p = 15'd3125;
			4'd12: p = 15'd3906;  4'd13: p = 15'd11719;
			4'd14: p = 15'd19531; default: p = 15'd31250;
		endcase
		return p;
	endfunction

	function automatic logic [4:0] expo_period(input logic [7:0] lvl);
		logic [4:0] p;
		priority if (lvl >= 8'd93) p = 5'd1;
		else if (lvl >= 8'd54) p = 5'd2;
		else if (lvl >= 8'd26) p = 5'd4;
		else if (lvl >= 8'd14) p = 5'd8;
		else if (lvl >= 8'd6) p = 5'd16;
		else p = 5'd30;
		return p;
	endfunction
endpackage
`default_nettype wire

// File: hdl/three_voice_oscillator_envelope_core.sv
// Three-voice oscillator/envelope core. One transaction enters per cycle
// while the result register is empty or being taken; the result is valid in
// the cycle after acceptance, set by the single state-update pass and the
// output register. Asynchronous reset clears the register file, phases and
// envelopes and loads the noise seeds. Depends on tvoc_pkg, tvoc_voice, tvoc_wave.
`default_nettype none
module three_voice_oscillator_envelope_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [4:0]  addr,
	input  wire logic [7:0]  wdata,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       rdata,
	output logic [11:0]      wave_a,
	output logic [11:0]      wave_b,
	output logic [11:0]      wave_c,
	output logic [7:0]       level_a,
	output logic [7:0]       level_b,
	output logic [7:0]       level_c
);
	import tvoc_pkg::*;

	logic [7:0] regs_q [32];
	voice_state_t vs_q [3];
	voice_state_t vt [3];
	voice_state_t vn [3];
	logic [2:0] rose;
	logic [7:0] osc_rb_q, env_rb_q;
	logic [11:0] wv [3];
	logic [11:0] wv_n [3];
	logic [7:0] rd;
	logic [7:0] regs_n [32];
	logic acc;

	assign in_ready = !out_valid || out_ready;
	assign acc = in_valid && in_ready;

	for (genvar v = 0; v < 3; v++) begin : g_v
		tvoc_voice u_voice (
			.cur(vs_q[v]),
			.freq({regs_q[7*v+1], regs_q[7*v]}),
			.ctl(regs_q[7*v+4]), .ad(regs_q[7*v+5]), .sr(regs_q[7*v+6]),
			.nxt(vt[v]), .rose(rose[v])
		);
		// waveform of the tick result, for the voice-three readback
		tvoc_wave u_wt (
			.ctl(regs_q[7*v+4]), .phase(vn[v].phase),
			.src_msb(vn[(v+2)%3].phase[23]),
			.pw({regs_q[7*v+3][3:0], regs_q[7*v+2]}),
			.lfsr(vn[v].lfsr), .wave(wv[v])
		);
		// waveform after this item
		tvoc_wave u_wo (
			.ctl(regs_n[7*v+4]), .phase(vn[v].phase),
			.src_msb(vn[(v+2)%3].phase[23]),
			.pw({regs_n[7*v+3][3:0], regs_n[7*v+2]}),
			.lfsr(vn[v].lfsr), .wave(wv_n[v])
		);
	end

	always_comb begin
		for (int v = 0; v < 3; v++) vn[v] = vs_q[v];
		for (int i = 0; i < 32; i++) regs_n[i] = regs_q[i];
		rd = 8'h00;
		unique case (op)
			OP_TICK: begin
				for (int v = 0; v < 3; v++) begin
					vn[v] = vt[v];
					if (regs_q[7*v+4][1] && rose[(v+2)%3]) vn[v].phase = '0;
				end
			end
			OP_WRITE: begin
				for (int v = 0; v < 3; v++) begin
					if (addr == 5'(7*v+4)) begin
						if (wdata[0] && !regs_q[7*v+4][0]) begin
							vn[v].ephase = EP_ATTACK;
							vn[v].ecount = '0;
						end
						if (!wdata[0] && regs_q[7*v+4][0]) begin
							vn[v].ephase = EP_RELEASE;
							vn[v].ecount = '0;
						end
						if (wdata[3]) vn[v].phase = '0;
					end
				end
				regs_n[addr] = wdata;
			end
			OP_READ: begin
				priority if (addr == REG_OSC3) rd = osc_rb_q;
				else if (addr == REG_ENV3) rd = env_rb_q;
				else if (addr == REG_POT_X || addr == REG_POT_Y) rd = 8'hFF;
				else rd = regs_q[addr];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 32; i++) regs_q[i] <= 8'h00;
			for (int v = 0; v < 3; v++) begin
				vs_q[v] <= '{phase: '0, lfsr: LFSR_RESET, level: '0,
					ephase: EP_RELEASE, rcount: '0, ecount: '0};
			end
			osc_rb_q <= 8'h00;
			env_rb_q <= 8'h00;
			out_valid <= 1'b0;
		end else begin
			if (acc) begin
				for (int i = 0; i < 32; i++) regs_q[i] <= regs_n[i];
				for (int v = 0; v < 3; v++) vs_q[v] <= vn[v];
				if (op == OP_TICK) begin
					osc_rb_q <= wv[2][11:4];
					env_rb_q <= vn[2].level;
				end
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (acc) begin
			rdata   <= rd;
			wave_a  <= wv_n[0];
			wave_b  <= wv_n[1];
			wave_c  <= wv_n[2];
			level_a <= vn[0].level;
			level_b <= vn[1].level;
			level_c <= vn[2].level;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rdata) && $stable(level_c))
		else $error("result changed while stalled");
	a_test_zero: assert property (@(posedge clk) disable iff (!arst_n)
		acc && op == OP_TICK && regs_q[4][3] |=> vs_q[0].phase == 24'h0)
		else $error("test bit did not hold phase");
	a_lfsr_live: assert property (@(posedge clk) disable iff (!arst_n)
		vs_q[0].lfsr != 23'h0)
		else $error("noise register stuck at zero");
endmodule
`default_nettype wire

// File: hdl/tvoc_wave.sv
// Waveform generator for one voice: triangle/saw/pulse/noise combined by AND.
// Uses tvoc_pkg.
`default_nettype none
module tvoc_wave (
	input  wire logic [7:0]  ctl,
	input  wire logic [23:0] phase,
	input  wire logic        src_msb,
	input  wire logic [11:0] pw,
	input  wire logic [22:0] lfsr,
	output logic [11:0]      wave
);
	import tvoc_pkg::*;
	logic [23:0] p;
	logic [11:0] tri_v, res;
	always_comb begin
		p = phase;
		if (ctl[2] && src_msb) p[23] = ~p[23];
		tri_v = p[22:11];
		if (p[23]) tri_v = ~tri_v;
		res = 12'hFFF;
		if (ctl[4]) res &= tri_v;
		if (ctl[5]) res &= phase[23:12];
		if (ctl[6]) res &= (phase[23:12] >= pw) ? 12'hFFF : 12'h000;
		if (ctl[7]) res &= {lfsr[20], lfsr[18], lfsr[14], lfsr[11],
			lfsr[9], lfsr[5], lfsr[2], lfsr[0], 4'h0};
		wave = (ctl[7:4] == 4'h0 || ctl[3]) ? 12'h000 : res;
	end
endmodule
`default_nettype wire

// File: hdl/tvoc_voice.sv
// Next-state logic of one voice on a tick: phase add, noise shift, envelope.
// Sync is applied outside. Uses tvoc_pkg.
`default_nettype none
module tvoc_voice (
	input  wire tvoc_pkg::voice_state_t cur,
	input  wire logic [15:0]  freq,
	input  wire logic [7:0]   ctl,
	input  wire logic [7:0]   ad,
	input  wire logic [7:0]   sr,
	output tvoc_pkg::voice_state_t nxt,
	output logic              rose
);
	import tvoc_pkg::*;
	logic [3:0]  rate;
	logic [14:0] rc;
	logic [4:0]  ec;
	logic [7:0]  sus;
	always_comb begin
		nxt = cur;
		rose = 1'b0;
		if (ctl[3]) begin
			nxt.phase = '0;
		end else begin
			nxt.phase = cur.phase + {8'h00, freq};
			rose = !cur.phase[23] && nxt.phase[23];
			if (!cur.phase[19] && nxt.phase[19])
				nxt.lfsr = {cur.lfsr[21:0], cur.lfsr[22] ^ cur.lfsr[17]};
		end
		unique case (cur.ephase)
			EP_ATTACK: rate = ad[7:4];
			EP_DECAY:  rate = ad[3:0];
			default:   rate = sr[3:0];
		endcase
		sus = {sr[7:4], sr[7:4]};
		rc = cur.rcount + 15'd1;
		ec = cur.ecount + 5'd1;
		nxt.rcount = rc;
		if (rc >= env_step_len(rate)) begin
			nxt.rcount = '0;
			if (cur.ephase == EP_ATTACK) begin
				if (cur.level != 8'hFF) nxt.level = cur.level + 8'd1;
				if (cur.level >= 8'hFE) begin
					nxt.ephase = EP_DECAY;
					nxt.ecount = '0;
				end
			end else begin
				nxt.ecount = ec;
				if (ec >= expo_period(cur.level)) begin
					nxt.ecount = '0;
					if (cur.ephase == EP_DECAY) begin
						if (cur.level > sus) nxt.level = cur.level - 8'd1;
					end else if (cur.level != 8'h00) begin
						nxt.level = cur.level - 8'd1;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

// File: tb/three_voice_oscillator_envelope_core_tb.sv
// Testbench for three_voice_oscillator_envelope_core: random register writes,
// reads and chip ticks checked against a behavioral predictor.
// Depends on tvoc_pkg and the core RTL.
`default_nettype none
module three_voice_oscillator_envelope_core_tb;
	import tvoc_pkg::*;

	typedef struct packed {
		logic [7:0]  rdata;
		logic [11:0] wa, wb, wc;
		logic [7:0]  la, lb, lc;
	} chip_out_t;

	class chip_scoreboard;
		logic [7:0]  regs [32];
		logic [23:0] ph [3];
		logic [22:0] nz [3];
		logic [7:0]  lvl [3];
		logic [1:0]  ep [3];
		logic [14:0] rc [3];
		logic [4:0]  ec [3];
		logic [7:0]  osc3, env3;
		chip_out_t   pending [$];
		int          errors, checked, n_tick, n_wr, n_rd;

		function new();
			for (int i = 0; i < 32; i++) regs[i] = 8'h00;
			for (int n = 0; n < 3; n++) begin
				ph[n] = '0; nz[n] = LFSR_RESET; lvl[n] = '0;
				ep[n] = EP_RELEASE; rc[n] = '0; ec[n] = '0;
			end
			osc3 = '0; env3 = '0;
			errors = 0; checked = 0; n_tick = 0; n_wr = 0; n_rd = 0;
		endfunction

		function int src_of(int n);
			return (n + 2) % 3;
		endfunction

		function logic [14:0] period_of(logic [3:0] r);
			case (r)
				4'd0: return 15'd8;       4'd1: return 15'd31;
				4'd2: return 15'd62;      4'd3: return 15'd94;
				4'd4: return 15'd148;     4'd5: return 15'd219;
				4'd6: return 15'd266;     4'd7: return 15'd312;
				4'd8: return 15'd391;     4'd9: return 15'd976;
				4'd10: return 15'd1953;   4'd11: return 15'd3125;
				4'd12: return 15'd3906;   4'd13: return 15'd11719;
				4'd14: return 15'd19531;
				default: return 15'd31250;
			endcase
		endfunction

		function logic [4:0] decay_div(logic [7:0] l);
			if (l >= 8'd93) return 5'd1;
			if (l >= 8'd54) return 5'd2;
			if (l >= 8'd26) return 5'd4;
			if (l >= 8'd14) return 5'd8;
			if (l >= 8'd6) return 5'd16;
			return 5'd30;
		endfunction

		function void step_envelope(int n);
			logic [7:0] ad, sr;
			logic [3:0] r;
			ad = regs[n*7+5];
			sr = regs[n*7+6];
			r = (ep[n] == EP_ATTACK) ? ad[7:4] : (ep[n] == EP_DECAY) ? ad[3:0] : sr[3:0];
			rc[n] = rc[n] + 15'd1;
			if (rc[n] < period_of(r)) return;
			rc[n] = '0;
			if (ep[n] == EP_ATTACK) begin
				if (lvl[n] != 8'hFF) lvl[n]++;
				if (lvl[n] == 8'hFF) begin
					ep[n] = EP_DECAY;
					ec[n] = '0;
				end
				return;
			end
			ec[n] = ec[n] + 5'd1;
			if (ec[n] < decay_div(lvl[n])) return;
			ec[n] = '0;
			if (ep[n] == EP_DECAY) begin
				if (int'(lvl[n]) > int'(sr[7:4]) * 17) lvl[n]--;
			end else if (lvl[n] != 0) begin
				lvl[n]--;
			end
		endfunction

		function logic [11:0] wave_of(int n);
			logic [7:0]  ctl;
			logic [23:0] p;
			logic [11:0] res, tri_v, pw;
			logic [22:0] z;
			ctl = regs[n*7+4];
			res = 12'hFFF;
			if (ctl[7:4] == 4'h0 || ctl[3]) return 12'h000;
			if (ctl[4]) begin
				p = ph[n];
				if (ctl[2] && ph[src_of(n)][23]) p[23] = ~p[23];
				tri_v = p[22:11];
				res &= p[23] ? ~tri_v : tri_v;
			end
			if (ctl[5]) res &= ph[n][23:12];
			if (ctl[6]) begin
				pw = {regs[n*7+3][3:0], regs[n*7+2]};
				res &= (ph[n][23:12] >= pw) ? 12'hFFF : 12'h000;
			end
			if (ctl[7]) begin
				z = nz[n];
				res &= {z[20], z[18], z[14], z[11], z[9], z[5], z[2], z[0], 4'h0};
			end
			return res;
		endfunction

		function void tick();
			bit rose [3];
			logic [23:0] prev;
			logic [15:0] f;
			logic [11:0] w3;
			for (int n = 0; n < 3; n++) begin
				prev = ph[n];
				rose[n] = 0;
				if (regs[n*7+4][3]) begin
					ph[n] = '0;
				end else begin
					f = {regs[n*7+1], regs[n*7]};
					ph[n] = prev + 24'(f);
					rose[n] = !prev[23] && ph[n][23];
					if (!prev[19] && ph[n][19]) nz[n] = {nz[n][21:0], nz[n][22] ^ nz[n][17]};
				end
				step_envelope(n);
			end
			for (int n = 0; n < 3; n++)
				if (regs[n*7+4][1] && rose[src_of(n)]) ph[n] = '0;
			w3 = wave_of(2);
			osc3 = w3[11:4];
			env3 = lvl[2];
		endfunction

		function void note_input(logic [1:0] op, logic [4:0] a, logic [7:0] d);
			chip_out_t e;
			int n;
			e.rdata = '0;
			if (op == OP_TICK) begin
				tick();
				n_tick++;
			end else if (op == OP_WRITE) begin
				n_wr++;
				if (a < 21 && a % 7 == 4) begin
					n = a / 7;
					if (d[0] && !regs[a][0]) begin
						ep[n] = EP_ATTACK;
						ec[n] = '0;
					end
					if (!d[0] && regs[a][0]) begin
						ep[n] = EP_RELEASE;
						ec[n] = '0;
					end
					if (d[3]) ph[n] = '0;
				end
				regs[a] = d;
			end else if (op == OP_READ) begin
				n_rd++;
				if (a == REG_OSC3) e.rdata = osc3;
				else if (a == REG_ENV3) e.rdata = env3;
				else if (a == REG_POT_X || a == REG_POT_Y) e.rdata = 8'hFF;
				else e.rdata = regs[a];
			end
			e.wa = wave_of(0); e.wb = wave_of(1); e.wc = wave_of(2);
			e.la = lvl[0]; e.lb = lvl[1]; e.lc = lvl[2];
			pending.push_back(e);
		endfunction

		function void check_result(chip_out_t got);
			chip_out_t e;
			checked++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
				return;
			end
			e = pending.pop_front();
			if (e !== got) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch #%0d: exp rd=%h w=%h/%h/%h l=%h/%h/%h",
						checked, e.rdata, e.wa, e.wb, e.wc, e.la, e.lb, e.lc);
					$display("    got rd=%h w=%h/%h/%h l=%h/%h/%h",
						got.rdata, got.wa, got.wb, got.wc, got.la, got.lb, got.lc);
				end
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, out_ready = 0;
	logic [1:0] op = '0;
	logic [4:0] addr = '0;
	logic [7:0] wdata = '0;
	logic in_ready, out_valid;
	logic [7:0] rdata, level_a, level_b, level_c;
	logic [11:0] wave_a, wave_b, wave_c;
	bit calm = 0;

	chip_scoreboard sb = new();

	three_voice_oscillator_envelope_core dut (.*);

	initial forever #5 clk = ~clk;

	initial begin
		#20000000;
		$display("three_voice_oscillator_envelope_core verification failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) sb.note_input(op, addr, wdata);
			if (out_valid && out_ready)
				sb.check_result({rdata, wave_a, wave_b, wave_c, level_a, level_b, level_c});
			out_ready <= calm || ($urandom_range(99) >= 15);
		end
	end

	// send one transaction, holding it until accepted; valid stays up for the next
	task automatic send(logic [1:0] o, logic [4:0] a, logic [7:0] d);
		if (!calm && $urandom_range(99) < 15) begin
			in_valid <= 0;
			do @(posedge clk); while (!calm && $urandom_range(99) < 15);
		end
		in_valid <= 1; op <= o; addr <= a; wdata <= d;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic ticks(int n);
		repeat (n) send(OP_TICK, '0, '0);
	endtask

	initial begin
		int k, v;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: fast envelope, pulse, sync/ring, test bit, odd opcode
		send(OP_WRITE, 5'd0, 8'hFF); send(OP_WRITE, 5'd1, 8'hFF);
		send(OP_WRITE, 5'd2, 8'h00); send(OP_WRITE, 5'd3, 8'hF8);
		send(OP_WRITE, 5'd5, 8'h00); send(OP_WRITE, 5'd6, 8'hF0);
		send(OP_WRITE, 5'd4, 8'h41);
		send(OP_WRITE, 5'd11, 8'h80); send(OP_WRITE, 5'd8, 8'h40);
		send(OP_WRITE, 5'd18, 8'h17); send(OP_WRITE, 5'd14, 8'h12);
		ticks(6);
		send(OP_READ, REG_OSC3, '0); send(OP_READ, REG_ENV3, '0);
		send(OP_READ, REG_POT_X, '0); send(OP_READ, REG_POT_Y, '0);
		send(OP_READ, 5'h1F, '0); send(OP_NOP, 5'h1F, 8'hFF);
		send(OP_WRITE, 5'd4, 8'hF8); ticks(2); send(OP_WRITE, 5'd4, 8'hF0);
		ticks(3);
		// random: mostly ticks so envelopes and noise move
		for (int i = 0; i < 950; i++) begin
			calm = (i >= 400 && i < 550);
			k = $urandom_range(99);
			v = $urandom;
			if (k < 55) send(OP_TICK, 5'(v), 8'(v >> 8));
			else if (k < 80) begin
				if ($urandom_range(3) == 0)
					send(OP_WRITE, 5'($urandom_range(2) * 7 + 4), 8'(v));
				else if ($urandom_range(3) == 0)
					send(OP_WRITE, 5'($urandom_range(2) * 7 + 5 + $urandom_range(1)),
						8'(v) & 8'h33);
				else send(OP_WRITE, 5'($urandom_range(31)), 8'(v));
			end else if (k < 97) send(OP_READ, 5'($urandom_range(31)), 8'(v));
			else send(OP_NOP, 5'(v), 8'(v >> 8));
		end
		calm = 0;
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		$display("covered %0d ticks, %0d writes, %0d reads; %0d results checked",
			sb.n_tick, sb.n_wr, sb.n_rd, sb.checked);
		if (sb.errors == 0) $display("three_voice_oscillator_envelope_core verification clean");
		else begin
			$display("%0d mismatches", sb.errors);
			$display("three_voice_oscillator_envelope_core verification failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
